// ===== hdl/lcd2c_pkg.sv =====
package lcd2c_pkg;

	// Input request: function code and character byte
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_code;
	} cmd_t;

	// One LCD register write
	typedef struct packed {
		logic       is_data;
		logic [7:0] byte_value;
		logic       last;
	} res_t;

	// Function codes
	localparam logic [1:0] FN_WRITE     = 2'd0;
	localparam logic [1:0] FN_FLUSH     = 2'd1;
	localparam logic [1:0] FN_HEARTBEAT = 2'd2;
	localparam logic [1:0] FN_INIT      = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_SET_ADDR   = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ROW0_ADDR  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_ROW1_ADDR  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_MODE       = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DISPLAY_ON = 3'd4;

	// Character codes
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Spinner glyph sequence
	function automatic logic [7:0] spin_glyph(input logic [1:0] idx);
		logic [7:0] g;
		case (idx)
			2'd0:    g = 8'h7C;
			2'd1:    g = 8'h2F;
			2'd2:    g = 8'h2D;
			default: g = 8'hCD;
		endcase
		return g;
	endfunction

endpackage

// ===== hdl/lcd2c_line_mem.sv =====
module lcd2c_line_mem #(
	parameter int unsigned LINE_LENGTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic                           wr_line,
	input  logic [$clog2(LINE_LENGTH)-1:0] wr_idx,
	input  logic [7:0]                     wr_data,
	input  logic                           rd_en,
	input  logic                           rd_line,
	input  logic [$clog2(LINE_LENGTH)-1:0] rd_idx,
	output logic [7:0]                     rd_data
);

	logic [7:0] mem_q [0:1][0:LINE_LENGTH-1];
	logic       vld_q [0:1][0:LINE_LENGTH-1];
	logic [7:0] rd_q;
	logic       rd_vld_q;

	// Store bytes; no reset on the array itself
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_line][wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_line][rd_idx];
		end
	end

	// Track written entries; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 2; l++) begin
				for (int i = 0; i < LINE_LENGTH; i++) begin
					vld_q[l][i] <= 1'b0;
				end
			end
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_line][wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_line][rd_idx];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : 8'h00;

endmodule

// ===== hdl/char_lcd_two_line_console.sv =====
// Two-line text console for a character LCD.
// Requests enter on start/cmd and are taken at a clock edge where start is
// high and busy is low. cmd.func selects write character, flush row 1,
// heartbeat tick or initialize. Each LCD register write comes out on
// result for one cycle with strobe high; result.last marks the final write
// of a request. The receiver cannot stall, so no backpressure exists.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data and
// are taken only while the block is idle (cfg_ready follows !busy).
// An ordinary character or carriage return is absorbed in the accept
// cycle and busy never rises; newlines and the other functions hold busy
// high while they run. Each write passes through a pending register and
// the result register before it appears.
// One line byte is read from the line store per cycle, and one shared adder
// forms every address command; that read port sets the drawing rate.
// Each write is held until the next one or the end of the request, so the
// last flag is known; the final write shows in the cycle in which busy falls.
// Reset makes both lines read as zero bytes, selects line 0, position 0,
// heartbeat off, spinner at its first glyph, and loads register defaults.
module char_lcd_two_line_console #(
	parameter int unsigned LINE_LENGTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  lcd2c_pkg::cmd_t                  cmd,
	output logic                             strobe,
	output lcd2c_pkg::res_t                  result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lcd2c_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [7:0]                       cfg_data
);
	import lcd2c_pkg::*;

	localparam int unsigned IW = $clog2(LINE_LENGTH);
	localparam int unsigned CW = $clog2(LINE_LENGTH + 1);
	localparam logic [CW-1:0] LEN_FULL  = CW'(LINE_LENGTH);
	localparam logic [CW-1:0] LEN_SHORT = CW'(LINE_LENGTH - 1);
	localparam logic [4:0]    POS_FULL  = 5'(LINE_LENGTH);
	localparam logic [4:0]    POS_SHORT = 5'(LINE_LENGTH - 1);
	localparam logic [7:0]    HB_OFFSET = 8'(LINE_LENGTH - 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CMD_MODE = 4'd1;
	localparam logic [3:0] S_CMD_ON   = 4'd2;
	localparam logic [3:0] S_BLANK    = 4'd3;
	localparam logic [3:0] S_ROW_ADDR = 4'd4;
	localparam logic [3:0] S_ROW_DATA = 4'd5;
	localparam logic [3:0] S_HB_ADDR  = 4'd6;
	localparam logic [3:0] S_HB_GLYPH = 4'd7;
	localparam logic [3:0] S_FIN      = 4'd8;

	// Configuration registers
	logic [7:0] set_addr_q;
	logic [6:0] row0_addr_q;
	logic [6:0] row1_addr_q;
	logic [7:0] mode_q;
	logic [7:0] disp_on_q;

	// Console state
	logic [3:0]    state_q;
	logic [1:0]    func_q;
	logic          cur_q;
	logic [4:0]    pos_q;
	logic          hb_q;
	logic [1:0]    spin_q;
	logic          row_q;
	logic          which_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] len_q;
	logic          bline_q;
	logic [CW-1:0] blen_q;
	logic          btwo_q;

	// Output staging
	res_t pend_q;
	logic pend_v_q;
	logic strobe_q;
	res_t result_q;

	// Sequencer outputs
	logic          gen_v;
	logic          gen_is_data;
	logic [7:0]    gen_byte;
	logic [6:0]    add_base;
	logic [7:0]    add_off;
	logic [7:0]    add_sum;
	logic [4:0]    cur_len;
	logic          idle_store;
	logic          accept;
	logic [CW-1:0] nidx;

	// Memory port
	logic          wr_en;
	logic          wr_line;
	logic [IW-1:0] wr_idx;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_idx;
	logic [7:0]    rd_data;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign strobe    = strobe_q;
	assign result    = result_q;

	// Row length for the current line when storing characters
	assign cur_len = (hb_q && !cur_q) ? POS_SHORT : POS_FULL;
	assign idle_store = accept && (cmd.func == FN_WRITE) && (cmd.char_code != CH_CR)
		&& (cmd.char_code != CH_LF) && (pos_q < cur_len);

	// Shared address adder
	assign add_base = (state_q == S_ROW_ADDR && row_q) ? row1_addr_q : row0_addr_q;
	assign add_off  = (state_q == S_HB_ADDR) ? HB_OFFSET : 8'h00;
	assign add_sum  = set_addr_q + {1'b0, add_base} + add_off;

	assign nidx = idx_q + CW'(1);

	// Generate at most one write per sequencer step
	always_comb begin
		gen_v       = 1'b0;
		gen_is_data = 1'b0;
		gen_byte    = add_sum;
		case (state_q)
			S_CMD_MODE: begin
				gen_v    = 1'b1;
				gen_byte = mode_q;
			end
			S_CMD_ON: begin
				gen_v    = 1'b1;
				gen_byte = disp_on_q;
			end
			S_ROW_ADDR, S_HB_ADDR: begin
				gen_v = 1'b1;
			end
			S_ROW_DATA: begin
				gen_v       = (idx_q != len_q) && (rd_data != CH_NUL);
				gen_is_data = 1'b1;
				gen_byte    = rd_data;
			end
			S_HB_GLYPH: begin
				gen_v       = 1'b1;
				gen_is_data = 1'b1;
				gen_byte    = spin_glyph(spin_q);
			end
			default: begin
				gen_v = 1'b0;
			end
		endcase
	end

	// Memory write and read requests
	always_comb begin
		wr_en   = 1'b0;
		wr_line = cur_q;
		wr_idx  = pos_q[IW-1:0];
		wr_data = cmd.char_code;
		if (state_q == S_BLANK) begin
			wr_en   = 1'b1;
			wr_line = bline_q;
			wr_idx  = idx_q[IW-1:0];
			wr_data = CH_SPACE;
		end else if (idle_store) begin
			wr_en = 1'b1;
		end
		rd_en  = 1'b0;
		rd_idx = '0;
		if (state_q == S_ROW_ADDR) begin
			rd_en = 1'b1;
		end else if (state_q == S_ROW_DATA && nidx < LEN_FULL) begin
			rd_en  = 1'b1;
			rd_idx = nidx[IW-1:0];
		end
	end

	lcd2c_line_mem #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_line (wr_line),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_line (which_q),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_addr_q  <= 8'd128;
			row0_addr_q <= 7'd0;
			row1_addr_q <= 7'd64;
			mode_q      <= 8'd56;
			disp_on_q   <= 8'd12;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SET_ADDR:   set_addr_q  <= cfg_data;
				CFG_ROW0_ADDR:  row0_addr_q <= cfg_data[6:0];
				CFG_ROW1_ADDR:  row1_addr_q <= cfg_data[6:0];
				CFG_MODE:       mode_q      <= cfg_data;
				CFG_DISPLAY_ON: disp_on_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q  <= FN_WRITE;
			cur_q   <= 1'b0;
			pos_q   <= 5'd0;
			hb_q    <= 1'b0;
			spin_q  <= 2'd0;
			row_q   <= 1'b0;
			which_q <= 1'b0;
			idx_q   <= '0;
			len_q   <= '0;
			bline_q <= 1'b0;
			blen_q  <= '0;
			btwo_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= cmd.func;
						case (cmd.func)
							FN_WRITE: begin
								if (cmd.char_code == CH_LF) begin
									row_q   <= 1'b0;
									which_q <= !cur_q;
									state_q <= S_ROW_ADDR;
								end else if (idle_store) begin
									pos_q <= pos_q + 5'd1;
								end
							end
							FN_FLUSH: begin
								row_q   <= 1'b1;
								which_q <= cur_q;
								state_q <= S_ROW_ADDR;
							end
							FN_HEARTBEAT: begin
								state_q <= S_HB_ADDR;
							end
							default: begin
								cur_q   <= 1'b0;
								pos_q   <= 5'd0;
								state_q <= S_CMD_MODE;
							end
						endcase
					end
				end
				S_CMD_MODE: begin
					state_q <= S_CMD_ON;
				end
				S_CMD_ON: begin
					bline_q <= 1'b0;
					idx_q   <= '0;
					blen_q  <= LEN_FULL;
					btwo_q  <= 1'b1;
					state_q <= S_BLANK;
				end
				S_BLANK: begin
					if (idx_q == blen_q - CW'(1)) begin
						idx_q <= '0;
						if (btwo_q) begin
							btwo_q  <= 1'b0;
							bline_q <= 1'b1;
						end else if (func_q == FN_INIT) begin
							row_q   <= 1'b0;
							which_q <= 1'b0;
							state_q <= S_ROW_ADDR;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_ROW_ADDR: begin
					idx_q   <= '0;
					len_q   <= (hb_q && !row_q) ? LEN_SHORT : LEN_FULL;
					state_q <= S_ROW_DATA;
				end
				S_ROW_DATA: begin
					if (idx_q == len_q || rd_data == CH_NUL) begin
						if (!row_q) begin
							row_q   <= 1'b1;
							which_q <= !which_q;
							state_q <= S_ROW_ADDR;
						end else if (func_q == FN_WRITE) begin
							// Swap lines and blank the new current one
							cur_q   <= !cur_q;
							pos_q   <= 5'd0;
							bline_q <= !cur_q;
							idx_q   <= '0;
							blen_q  <= (hb_q && cur_q) ? LEN_SHORT : LEN_FULL;
							btwo_q  <= 1'b0;
							state_q <= S_BLANK;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						idx_q <= nidx;
					end
				end
				S_HB_ADDR: begin
					hb_q    <= 1'b1;
					state_q <= S_HB_GLYPH;
				end
				S_HB_GLYPH: begin
					spin_q  <= spin_q + 2'd1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold one write back until the next one shows whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else if (gen_v) begin
			pend_v_q <= 1'b1;
			strobe_q <= pend_v_q;
		end else if (state_q == S_FIN) begin
			pend_v_q <= 1'b0;
			strobe_q <= pend_v_q;
		end else begin
			strobe_q <= 1'b0;
		end
	end

	// Stage write payloads
	always_ff @(posedge clk) begin
		if (gen_v) begin
			pend_q.is_data    <= gen_is_data;
			pend_q.byte_value <= gen_byte;
			pend_q.last       <= 1'b0;
			result_q          <= pend_q;
		end else if (state_q == S_FIN) begin
			result_q <= {pend_q.is_data, pend_q.byte_value, 1'b1};
		end
	end

endmodule
